[design/bb_pkg.sv]
// ----------------------------------------------------------------------------
// bb_pkg
// Shared types, register indexes and divider constants of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb_pkg;

  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned RowW        = 13;
  localparam int unsigned HeightLimit = 4096;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 4'd1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } colv_t;

  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } flags_t;

  function automatic logic [7:0] chan(input pix_t p, input int unsigned k);
    logic [7:0] v;
    unique case (k)
      0:       v = p.r;
      1:       v = p.g;
      default: v = p.b;
    endcase
    return v;
  endfunction

  // floor(2^16 / d2) for each doubled window count
  function automatic logic [15:0] recip(input logic [4:0] d2);
    logic [15:0] v;
    unique case (d2)
      5'd2:    v = 16'd32768;
      5'd4:    v = 16'd16384;
      5'd6:    v = 16'd10922;
      5'd8:    v = 16'd8192;
      5'd12:   v = 16'd5461;
      5'd18:   v = 16'd3640;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

[design/bb_fifo.sv]
// ----------------------------------------------------------------------------
// bb_fifo
// Short word queue between the classifying front and the filter back end.
// ----------------------------------------------------------------------------
module bb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i)) else $error("fifo overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("fifo underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH)) else $error("fifo count out of range");

endmodule

[design/bb_ram.sv]
// ----------------------------------------------------------------------------
// bb_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/bb_front.sv]
// ----------------------------------------------------------------------------
// bb_front
// Frame registers and raster counters; classifies each word and queues all but in-frame drain words.
// ----------------------------------------------------------------------------
module bb_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  bb_pkg::pix_t                 pix_i,
  input  logic                         full_i,
  output logic                         push_o,
  output bb_pkg::flags_t               flags_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output bb_pkg::pix_t                 pix_o
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [10:0]     width_q;
  logic [12:0]     height_q;
  logic [CW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d, wm1;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d, hm1;
  logic            acc, in_frame, drop, emit, last, cfg_hit;

  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width_q - 11'd1);
    end
    if (height_q == '0) begin
      hm1 = '0;
    end else if (32'(height_q) > HeightLimit) begin
      hm1 = RowW'(HeightLimit - 1);
    end else begin
      hm1 = height_q - 13'd1;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && ((cfg_index_i == CFG_FRAME_WIDTH) ||
                                       (cfg_index_i == CFG_FRAME_HEIGHT));
  assign in_ready_o  = !full_i;
  assign acc         = in_valid_i && !full_i;
  assign in_frame    = (in_row_q <= hm1);
  assign drop        = in_frame && req_type_i;
  assign emit        = !((in_row_q == '0) || ((in_row_q == RowW'(1)) && (in_col_q == '0)));
  assign last        = (out_row_q == hm1) && (out_col_q == wm1);
  assign push_o      = acc && !drop;
  assign col_o       = in_col_q;
  assign pix_o       = pix_i;

  always_comb begin
    flags_o.emit     = emit;
    flags_o.top_ok   = (out_row_q != '0);
    flags_o.bot_ok   = (out_row_q != hm1);
    flags_o.left_ok  = (out_col_q != '0);
    flags_o.right_ok = (out_col_q != wm1);
    flags_o.last     = last;
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_hit) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (push_o) begin
      if (emit && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_col_q == wm1) begin
          in_col_d = '0;
          in_row_d = in_row_q + 1'b1;
        end else begin
          in_col_d = in_col_q + 1'b1;
        end
        if (emit) begin
          if (out_col_q == wm1) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd640;
      height_q  <= 13'd480;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CFG_FRAME_WIDTH)) begin
        width_q <= cfg_data_i[10:0];
      end
      if (cfg_valid_i && (cfg_index_i == CFG_FRAME_HEIGHT)) begin
        height_q <= cfg_data_i;
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

[design/bb_back.sv]
// ----------------------------------------------------------------------------
// bb_back
// Line stores, 3x3 window, clipped sums and rounded mean per channel.
// ----------------------------------------------------------------------------
module bb_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  bb_pkg::flags_t               flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  bb_pkg::pix_t                 pix_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bb_pkg::pix_t                 pix_o,
  output logic                         last_o
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic          en;
  logic          b_valid_q, byp_q;
  flags_t        b_flags_q;
  pix_t          b_pix_q, byp_up_q, byp_mid_q;
  logic [CW-1:0] b_col_q;
  pix_t          up_rd, mid_rd, up_eff, mid_eff;
  colv_t         cur, col1_q, col2_q;
  colv_t         win [3];

  logic          c_valid_q, c_last_q;
  logic [12:0]   c_x_q [3];
  logic [4:0]    c_d2_q;
  logic          d_valid_q, d_last_q;
  logic [27:0]   d_prod_q [3];
  logic [12:0]   d_x_q [3];
  logic [4:0]    d_d2_q;
  logic          out_valid_q, out_last_q;
  pix_t          out_pix_q;

  logic [11:0]   sum_c [3];
  logic [12:0]   x_c [3];
  logic [1:0]    nr, nc;
  logic [3:0]    cnt;
  logic [7:0]    q_c [3];

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  bb_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (en && b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (mid_eff),
    .re_i    (pop_o),
    .raddr_i (col_i),
    .rdata_o (up_rd)
  );

  bb_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (en && b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (b_pix_q),
    .re_i    (pop_o),
    .raddr_i (col_i),
    .rdata_o (mid_rd)
  );

  // same-column write in flight (single-pixel rows)
  assign up_eff  = byp_q ? byp_up_q  : up_rd;
  assign mid_eff = byp_q ? byp_mid_q : mid_rd;

  always_comb begin
    cur.top = up_eff;
    cur.mid = mid_eff;
    cur.bot = b_pix_q;
    win[0]  = col2_q;
    win[1]  = col1_q;
    win[2]  = cur;
  end

  always_comb begin
    logic [2:0] cm;
    cm = {b_flags_q.right_ok, 1'b1, b_flags_q.left_ok};
    nr  = 2'd1 + 2'(b_flags_q.top_ok) + 2'(b_flags_q.bot_ok);
    nc  = 2'd1 + 2'(b_flags_q.left_ok) + 2'(b_flags_q.right_ok);
    cnt = 4'(nr) * 4'(nc);
    for (int unsigned k = 0; k < 3; k++) begin
      sum_c[k] = '0;
      for (int unsigned j = 0; j < 3; j++) begin
        if (cm[j]) begin
          sum_c[k] = sum_c[k] + 12'(chan(win[j].mid, k));
          if (b_flags_q.top_ok) begin
            sum_c[k] = sum_c[k] + 12'(chan(win[j].top, k));
          end
          if (b_flags_q.bot_ok) begin
            sum_c[k] = sum_c[k] + 12'(chan(win[j].bot, k));
          end
        end
      end
      x_c[k] = {sum_c[k], 1'b0} + 13'(cnt);
    end
  end

  always_comb begin
    logic [11:0] qe;
    logic [12:0] rem;
    logic [11:0] qf;
    for (int unsigned k = 0; k < 3; k++) begin
      qe     = d_prod_q[k][27:16];
      rem    = d_x_q[k] - 13'(qe) * 13'(d_d2_q);
      qf     = qe + 12'(rem >= 13'(d_d2_q));
      q_c[k] = qf[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      byp_q       <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      col1_q      <= '0;
      col2_q      <= '0;
    end else if (en) begin
      b_valid_q   <= !empty_i;
      byp_q       <= b_valid_q && (b_col_q == col_i);
      c_valid_q   <= b_valid_q && b_flags_q.emit;
      d_valid_q   <= c_valid_q;
      out_valid_q <= d_valid_q;
      if (b_valid_q) begin
        col2_q <= col1_q;
        col1_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_flags_q  <= flags_i;
      b_pix_q    <= pix_i;
      b_col_q    <= col_i;
      byp_up_q   <= mid_eff;
      byp_mid_q  <= b_pix_q;
      c_last_q   <= b_flags_q.last;
      c_d2_q     <= {cnt, 1'b0};
      d_last_q   <= c_last_q;
      d_d2_q     <= c_d2_q;
      out_last_q <= d_last_q;
      out_pix_q  <= '{r: q_c[0], g: q_c[1], b: q_c[2]};
      for (int unsigned k = 0; k < 3; k++) begin
        c_x_q[k]    <= x_c[k];
        d_prod_q[k] <= 28'(c_x_q[k]) * 28'(recip(c_d2_q));
        d_x_q[k]    <= c_x_q[k];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = out_pix_q;
  assign last_o      = out_last_q;

  a_window_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(col1_q) && $stable(col2_q)) else $error("window moved in stall");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_pix_q))
    else $error("result dropped in stall");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> (c_d2_q != '0)) else $error("zero divisor");

endmodule

[design/box_blur_3x3_edge_averaged.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_averaged
// Streaming 3x3 box blur of RGB frames, window clipped at the frame edges.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while out_ready_i does not stall the back end, set by
//   the one-read, one-write line stores and the four-stage back end running in lockstep.
// Path: the word that releases a result (pixel n is released by slot n+W+1)
//   passes through a 2-word queue and then the registered back-end stages.
// Reset: counters cleared, width 640, height 480; line stores are not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_averaged #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [7:0]                  red_in_i,
  input  logic [7:0]                  green_in_i,
  input  logic [7:0]                  blue_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  red_out_o,
  output logic [7:0]                  green_out_o,
  output logic [7:0]                  blue_out_o,
  output logic                        frame_last_o
);
  import bb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned QW = CW + $bits(flags_t) + $bits(pix_t);

  pix_t          in_pix, f_pix, q_pix, o_pix;
  flags_t        f_flags, q_flags;
  logic [CW-1:0] f_col, q_col;
  logic          push, pop, full, empty;
  logic [QW-1:0] q_rdata;

  assign in_pix = '{r: red_in_i, g: green_in_i, b: blue_in_i};

  bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .pix_i       (in_pix),
    .full_i      (full),
    .push_o      (push),
    .flags_o     (f_flags),
    .col_o       (f_col),
    .pix_o       (f_pix)
  );

  bb_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_col, f_flags, f_pix}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {q_col, q_flags, q_pix} = q_rdata;

  bb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .flags_i     (q_flags),
    .col_i       (q_col),
    .pix_i       (q_pix),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_o       (o_pix),
    .last_o      (frame_last_o)
  );

  assign red_out_o   = o_pix.r;
  assign green_out_o = o_pix.g;
  assign blue_out_o  = o_pix.b;

endmodule

[tb/sv/box_blur_3x3_edge_averaged_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_averaged_tb
// Streams frames of assorted sizes, including the width and height extremes,
// through the blur and checks every output word against a line-store
// predictor. The sender runs in bursts and the receiver stalls on a pattern.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_averaged_tb;
  import bb_pkg::*;

  localparam int unsigned MaxW = 1024;
  localparam logic ReqPixel = 1'b0;
  localparam logic ReqDrain = 1'b1;

  typedef struct {
    logic       req;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } px_word_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } blur_word_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, req_type_i;
  logic [7:0] red_in_i, green_in_i, blue_in_i;
  logic out_valid_o, out_ready_i;
  logic [7:0] red_out_o, green_out_o, blue_out_o;
  logic frame_last_o;

  box_blur_3x3_edge_averaged i_dut (.*);

  px_word_t   pend_px[$];
  blur_word_t blur_q[$];
  int unsigned errors = 0;

  // predictor state
  pix_t        line_mem [4][MaxW];
  int unsigned cur_width, cur_height, slot_cnt;

  function automatic int unsigned eff_w();
    if (cur_width == 0) return 1;
    if (cur_width > MaxW) return MaxW;
    return cur_width;
  endfunction

  function automatic int unsigned eff_h();
    if (cur_height == 0) return 1;
    if (cur_height > HeightLimit) return HeightLimit;
    return cur_height;
  endfunction

  task automatic blur_predict(input px_word_t it);
    int unsigned w, h, total, t, o, ro, co, r0, r1, c0, c1, cnt;
    int unsigned sr, sg, sb;
    blur_word_t ex;
    pix_t p;
    w = eff_w();
    h = eff_h();
    total = w * h;
    t = slot_cnt;
    if (t < total) begin
      if (it.req == ReqDrain) return;
      p.r = it.r;
      p.g = it.g;
      p.b = it.b;
      line_mem[(t / w) % 4][t % w] = p;
    end
    if (t < w + 1) begin
      slot_cnt = t + 1;
      return;
    end
    o = t - w - 1;
    ro = o / w;
    co = o % w;
    r0 = (ro > 0) ? ro - 1 : ro;
    r1 = (ro + 1 < h) ? ro + 1 : ro;
    c0 = (co > 0) ? co - 1 : co;
    c1 = (co + 1 < w) ? co + 1 : co;
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    sr = 0;
    sg = 0;
    sb = 0;
    for (int unsigned r = r0; r <= r1; r++) begin
      for (int unsigned c = c0; c <= c1; c++) begin
        p = line_mem[r % 4][c];
        sr += p.r;
        sg += p.g;
        sb += p.b;
      end
    end
    ex.r = 8'((2 * sr + cnt) / (2 * cnt));
    ex.g = 8'((2 * sg + cnt) / (2 * cnt));
    ex.b = 8'((2 * sb + cnt) / (2 * cnt));
    ex.last = (o + 1 == total);
    slot_cnt = ex.last ? 0 : t + 1;
    blur_q.push_back(ex);
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // sender
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    px_word_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= ReqPixel;
      red_in_i   <= '0;
      green_in_i <= '0;
      blue_in_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        it.req = req_type_i;
        it.r = red_in_i;
        it.g = green_in_i;
        it.b = blue_in_i;
        blur_predict(it);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pend_px.size() > 0) begin
          it = pend_px.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= it.req;
          red_in_i   <= it.r;
          green_in_i <= it.g;
          blue_in_i  <= it.b;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int unsigned cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    blur_word_t ex;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (out_valid_o && out_ready_i) begin
        if (blur_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          ex = blur_q.pop_front();
          if (red_out_o !== ex.r) report("red", red_out_o, ex.r);
          if (green_out_o !== ex.g) report("green", green_out_o, ex.g);
          if (blue_out_o !== ex.b) report("blue", blue_out_o, ex.b);
          if (frame_last_o !== ex.last) report("frame_last", frame_last_o, ex.last);
        end
      end
      case ((cyc / 256) % 4)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= (cyc % 5 == 0);
        default: out_ready_i <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic push_px(input logic req, input int unsigned r, input int unsigned g,
                         input int unsigned b);
    px_word_t it;
    it.req = req;
    it.r = 8'(r);
    it.g = 8'(g);
    it.b = 8'(b);
    pend_px.push_back(it);
  endtask

  task automatic push_rand_px();
    push_px(ReqPixel, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // one frame: pixels, optional noise drains, then the flush slots unless cut short
  task automatic push_frame(input int unsigned w, input int unsigned h,
                            input bit noisy, input bit cut_short);
    int unsigned n;
    n = cut_short ? $urandom_range(1, w * h) : w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) push_px(ReqDrain, $urandom_range(0, 255), 0, 255);
      push_rand_px();
    end
    if (cut_short) return;
    for (int unsigned i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 5) == 0) push_rand_px();
      else push_px(ReqDrain, $urandom_range(0, 255), $urandom_range(0, 255), 0);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pend_px.size() != 0 || in_valid_i || blur_q.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(val);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_FRAME_WIDTH) cur_width = val & 32'h7FF;
    else if (idx == CFG_FRAME_HEIGHT) cur_height = val & 32'h1FFF;
    slot_cnt = 0;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int unsigned w, h, sent;
    cur_width = 640;
    cur_height = 480;
    slot_cnt = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FRAME_WIDTH;
    cfg_data_i  = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed 3x3: extreme channels, early drain, excess pixel as flush slot
    set_frame(3, 3);
    push_px(ReqPixel, 255, 0, 255);
    push_px(ReqPixel, 0, 255, 0);
    push_px(ReqDrain, 255, 255, 255);
    push_px(ReqPixel, 255, 255, 255);
    push_px(ReqPixel, 0, 0, 0);
    push_px(ReqPixel, 170, 85, 1);
    push_px(ReqPixel, 254, 128, 127);
    push_px(ReqPixel, 255, 255, 255);
    push_px(ReqPixel, 0, 0, 0);
    push_px(ReqPixel, 1, 2, 3);
    push_px(ReqPixel, 255, 255, 255);
    push_px(ReqDrain, 0, 0, 0);
    push_px(ReqPixel, 9, 9, 9);
    push_px(ReqDrain, 0, 0, 0);

    // zero sizes act as 1x1
    set_frame(0, 0);
    push_px(ReqPixel, 255, 255, 255);
    push_px(ReqDrain, 0, 0, 0);
    push_px(ReqDrain, 0, 0, 0);

    // oversize width clamps, then oversize height clamps; both cut short
    set_frame(13'h1FFF, 1);
    for (int unsigned i = 0; i < 40; i++) push_rand_px();
    set_frame(1, 13'h1FFF);
    for (int unsigned i = 0; i < 40; i++) push_rand_px();

    // random frames; sometimes abandoned mid-frame by a register write
    sent = 0;
    while (sent < 950) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 32) : $urandom_range(1, 20);
      h = $urandom_range(1, 6);
      set_frame(w, h);
      push_frame(w, h, $urandom_range(0, 1), $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 2) == 0) push_frame(w, h, 1'b1, 1'b0);
      sent += pend_px.size();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[box_blur_3x3_edge_averaged] OK");
    end else begin
      $display("[box_blur_3x3_edge_averaged] ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("[box_blur_3x3_edge_averaged] ERROR");
    $finish;
  end

endmodule

[filelist.f]
design/bb_pkg.sv
design/bb_fifo.sv
design/bb_ram.sv
design/bb_front.sv
design/bb_back.sv
design/box_blur_3x3_edge_averaged.sv
tb/sv/box_blur_3x3_edge_averaged_tb.sv
